FILE: rtl/core/rcw_pkg.sv
`default_nettype none
package rcw_pkg;

  typedef enum logic [1:0] {
    CMD_ACK     = 2'd0,
    CMD_TIMEOUT = 2'd1,
    CMD_START   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] ack_number;
  } in_item_t;

  typedef struct packed {
    logic [31:0] congestion_window;
    logic [31:0] slow_start_threshold;
    logic [16:0] send_window_packets;
    logic        in_fast_recovery;
    logic [7:0]  duplicate_count;
    logic        retransmit_now;
    logic [31:0] retransmit_sequence;
    logic [31:0] acked_base;
    logic        base_advanced;
  } out_item_t;

  localparam logic [31:0] MAX32     = 32'hFFFF_FFFF;
  localparam logic [16:0] MAX_PKTS  = 17'h1_FFFF;
  localparam logic [7:0]  MAX_DUPS  = 8'hFF;

endpackage
`default_nettype wire

FILE: rtl/core/rcw_in_if.sv
`default_nettype none
interface rcw_in_if;
  import rcw_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/rcw_out_if.sv
`default_nettype none
interface rcw_out_if;
  import rcw_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/rcw_recip_div.sv
`default_nettype none
module rcw_recip_div #(
  parameter int QW = 33
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [31:0]   divisor,
  output logic               done,
  output logic [QW-1:0]      quotient
);
  localparam int CW = $clog2(QW + 1);

  logic          busy;
  logic [CW-1:0] count;
  logic [31:0]   rem;
  logic [31:0]   div_r;
  logic [32:0]   shifted;
  logic          fits;

  always_comb begin
    shifted = {rem, (count == '0)};
    fits    = (shifted >= {1'b0, div_r});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= busy && !start && (count == CW'(QW - 1));
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == CW'(QW - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      div_r <= divisor;
    end else if (busy) begin
      rem      <= fits ? 32'(shifted - {1'b0, div_r}) : shifted[31:0];
      quotient <= {quotient[QW-2:0], fits};
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/reno_congestion_window.sv
`default_nettype none
// Reno congestion window. Takes ACK, timeout and connection-start events and
// returns one result per event with the updated window, threshold and
// retransmit request. Timeouts, starts, duplicate ACKs and new ACKs in slow
// start or recovery finish directly, their result registered as the event is
// taken. A new ACK in congestion avoidance computes 1/cwnd on a bit-serial
// divider, one quotient bit per cycle over 2*FRACTION_BITS+1 bits, and adds
// it to the window; no other event is taken until that result is in the
// output register. Events are taken one at a time; a new event is taken
// only when the output register is empty or its result leaves in the same
// cycle.
module reno_congestion_window
  import rcw_pkg::*;
#(
  parameter int FRACTION_BITS = 16,
  parameter int DUP_THRESHOLD = 3
) (
  input  wire logic        clk,
  input  wire logic        rst,
  rcw_in_if.sink           events,
  rcw_out_if.source        results,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data
);
  localparam int          QW      = 2 * FRACTION_BITS + 1;
  localparam int          SW      = (QW > 32 ? QW : 32) + 1;
  localparam logic [31:0] ONE_Q   = 32'(64'd1 << FRACTION_BITS);
  localparam logic [31:0] THREE_Q = 32'(64'd3 << FRACTION_BITS);
  localparam logic [31:0] INIT_TH = 32'(64'd16 << FRACTION_BITS);
  localparam logic [7:0]  DUP_TH  = 8'(DUP_THRESHOLD);

  state_t      state, state_next;
  logic [31:0] init_thresh;
  logic [31:0] window, window_next;
  logic [31:0] threshold, threshold_next;
  logic [7:0]  dup_acks, dup_next, dup_inc;
  logic        recovering, rec_next;
  logic [31:0] highest_ack, highest_next;
  logic        advanced, rexmit, ca_start;
  logic [31:0] halved, halved_floor;
  logic [32:0] win_plus_one, th_plus_three;
  logic [31:0] win_inc_sat, th_three_sat;

  logic        out_valid;
  out_item_t   out_item;
  logic        out_free, accept, div_start, div_done, finish;
  logic [QW-1:0] quotient;
  logic [SW-1:0] ca_sum;
  logic [31:0]   ca_window;
  cmd_t          cmd;

  function automatic logic [16:0] packets(input logic [31:0] w);
    logic [32:0] s;
    logic [32:0] p;
    s = {1'b0, w} + {1'b0, ONE_Q} - 33'd1;
    p = s >> FRACTION_BITS;
    return (p > 33'(MAX_PKTS)) ? MAX_PKTS : p[16:0];
  endfunction

  rcw_recip_div #(.QW(QW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (window),
    .done     (div_done),
    .quotient (quotient)
  );

  assign out_free = !out_valid || results.ready;
  assign accept   = events.valid && events.ready;
  assign cmd      = cmd_t'(events.payload.command);

  always_comb begin
    halved        = window >> 1;
    halved_floor  = (halved < ONE_Q) ? ONE_Q : halved;
    win_plus_one  = {1'b0, window} + {1'b0, ONE_Q};
    win_inc_sat   = win_plus_one[32] ? MAX32 : win_plus_one[31:0];
    th_plus_three = {1'b0, halved_floor} + {1'b0, THREE_Q};
    th_three_sat  = th_plus_three[32] ? MAX32 : th_plus_three[31:0];
    dup_inc       = (dup_acks == MAX_DUPS) ? dup_acks : dup_acks + 8'd1;
    ca_sum        = SW'(window) + SW'(quotient);
    ca_window     = (ca_sum[SW-1:32] != '0) ? MAX32 : ca_sum[31:0];
  end

  always_comb begin
    window_next    = window;
    threshold_next = threshold;
    dup_next       = dup_acks;
    rec_next       = recovering;
    highest_next   = highest_ack;
    advanced       = 1'b0;
    rexmit         = 1'b0;
    ca_start       = 1'b0;
    unique case (cmd)
      CMD_START: begin
        highest_next   = events.payload.ack_number;
        window_next    = ONE_Q;
        threshold_next = init_thresh;
        dup_next       = '0;
        rec_next       = 1'b0;
      end
      CMD_TIMEOUT: begin
        threshold_next = halved_floor;
        window_next    = ONE_Q;
        dup_next       = '0;
        rec_next       = 1'b0;
      end
      CMD_ACK: begin
        priority if (events.payload.ack_number > highest_ack) begin
          dup_next     = '0;
          advanced     = 1'b1;
          highest_next = events.payload.ack_number;
          priority if (recovering) begin
            rec_next    = 1'b0;
            window_next = threshold;
          end else if (window < threshold) begin
            window_next = win_inc_sat;
          end else begin
            ca_start = 1'b1;
          end
        end else if (events.payload.ack_number == highest_ack) begin
          dup_next = dup_inc;
          priority if (dup_inc == DUP_TH && !recovering) begin
            threshold_next = halved_floor;
            window_next    = th_three_sat;
            rec_next       = 1'b1;
            rexmit         = 1'b1;
          end else if (dup_inc > DUP_TH && recovering) begin
            window_next = win_inc_sat;
          end else begin
          end
        end else begin
        end
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept && ca_start) state_next = ST_DIVIDE;
      ST_DIVIDE: if (div_done) state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    events.ready = 1'b0;
    div_start    = 1'b0;
    finish       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        events.ready = out_free;
        div_start    = accept && ca_start;
      end
      ST_DIVIDE: begin
      end
      ST_FINISH: begin
        finish = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      init_thresh <= INIT_TH;
      window      <= ONE_Q;
      threshold   <= INIT_TH;
      dup_acks    <= '0;
      recovering  <= 1'b0;
      highest_ack <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        init_thresh <= cfg_wr_data;
      end
      if (accept) begin
        window      <= window_next;
        threshold   <= threshold_next;
        dup_acks    <= dup_next;
        recovering  <= rec_next;
        highest_ack <= highest_next;
      end else if (finish) begin
        window <= ca_window;
      end
      if ((accept && !ca_start) || finish) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !ca_start) begin
      out_item.congestion_window    <= window_next;
      out_item.slow_start_threshold <= threshold_next;
      out_item.send_window_packets  <= packets(window_next);
      out_item.in_fast_recovery     <= rec_next;
      out_item.duplicate_count      <= dup_next;
      out_item.retransmit_now       <= rexmit;
      out_item.retransmit_sequence  <= rexmit ? events.payload.ack_number : '0;
      out_item.acked_base           <= highest_next;
      out_item.base_advanced        <= advanced;
    end else if (finish) begin
      out_item.congestion_window    <= ca_window;
      out_item.slow_start_threshold <= threshold;
      out_item.send_window_packets  <= packets(ca_window);
      out_item.in_fast_recovery     <= recovering;
      out_item.duplicate_count      <= dup_acks;
      out_item.retransmit_now       <= 1'b0;
      out_item.retransmit_sequence  <= '0;
      out_item.acked_base           <= highest_ack;
      out_item.base_advanced        <= 1'b1;
    end
  end

  assign results.valid   = out_valid;
  assign results.payload = out_item;
endmodule
`default_nettype wire
